@@ rtl/ttw_pkg.sv @@
// ttw_pkg: shared constants, payload structs, state codes and address helpers
// for the text terminal writer. No dependencies.
package ttw_pkg;

  localparam int MAX_COLS         = 240;
  localparam int MAX_ROWS         = 68;
  localparam int SCROLLBACK_LINES = 200;

  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int HIST_DEPTH = SCROLLBACK_LINES * MAX_COLS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [15:0] RESET_CELL   = 16'h0720;

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_READ_LIVE  = 2'd1,
    OP_READ_HIST  = 2'd2,
    OP_SET_CURSOR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_TEXT_COLOR = 3'd0,
    REG_COLS       = 3'd1,
    REG_ROWS       = 3'd2,
    REG_HEADER     = 3'd3,
    REG_STATUS     = 3'd4,
    REG_EDITOR     = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PUSH_LINE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_MOVE_RD,
    ST_MOVE_WR
  } state_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_code;
    logic [6:0] row;
    logic [7:0] col;
    logic [7:0] history_line;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_entry;
    logic        read_error;
    logic [6:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic        scrolled;
    logic [7:0]  lines_kept;
  } res_t;

  // Effective screen layout derived from the configuration registers.
  typedef struct packed {
    logic [7:0] text_color;
    logic [7:0] ncols;
    logic [6:0] nrows;
    logic       origin;
    logic [6:0] cnt;
    logic [6:0] max_r;
    logic       editor;
  } layout_t;

  function automatic logic [GRID_AW-1:0] grid_addr(input logic [6:0] r, input logic [7:0] c);
    int a;
    a = int'(r) * MAX_COLS + int'(c);
    return a[GRID_AW-1:0];
  endfunction

  function automatic logic [HIST_AW-1:0] hist_addr(input logic [7:0] s, input logic [7:0] c);
    int a;
    a = int'(s) * MAX_COLS + int'(c);
    return a[HIST_AW-1:0];
  endfunction

  // Ring index wrap; input is known to stay below twice the ring size.
  function automatic logic [7:0] wrap_line(input logic [8:0] s);
    logic [8:0] w;
    w = (s >= 9'(SCROLLBACK_LINES)) ? s - 9'(SCROLLBACK_LINES) : s;
    return w[7:0];
  endfunction

endpackage

@@ rtl/ttw_ram.sv @@
// ttw_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ttw_regs.sv @@
// ttw_regs: configuration register file and screen layout decode.
// Depends on ttw_pkg.
module ttw_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  output ttw_pkg::layout_t lay
);

  logic [7:0] text_color;
  logic [7:0] cols_in_use;
  logic [6:0] rows_in_use;
  logic       header_on;
  logic       status_on;
  logic       editor_on;
  logic [1:0] chrome;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color  <= 8'd7;
      cols_in_use <= 8'd80;
      rows_in_use <= 7'd25;
      header_on   <= 1'b1;
      status_on   <= 1'b1;
      editor_on   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttw_pkg::REG_TEXT_COLOR: text_color  <= cfg_data;
        ttw_pkg::REG_COLS:       cols_in_use <= cfg_data;
        ttw_pkg::REG_ROWS:       rows_in_use <= cfg_data[6:0];
        ttw_pkg::REG_HEADER:     header_on   <= cfg_data[0];
        ttw_pkg::REG_STATUS:     status_on   <= cfg_data[0];
        ttw_pkg::REG_EDITOR:     editor_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lay.text_color = text_color;
    if (cols_in_use == 8'd0) begin
      lay.ncols = 8'd1;
    end else if (cols_in_use > 8'(ttw_pkg::MAX_COLS)) begin
      lay.ncols = 8'(ttw_pkg::MAX_COLS);
    end else begin
      lay.ncols = cols_in_use;
    end
    if (rows_in_use == 7'd0) begin
      lay.nrows = 7'd1;
    end else if (rows_in_use > 7'(ttw_pkg::MAX_ROWS)) begin
      lay.nrows = 7'(ttw_pkg::MAX_ROWS);
    end else begin
      lay.nrows = rows_in_use;
    end
    chrome     = editor_on ? 2'd0 : 2'({1'b0, header_on}) + 2'({1'b0, status_on});
    lay.cnt    = (lay.nrows > 7'(chrome)) ? lay.nrows - 7'(chrome) : 7'd1;
    lay.origin = !editor_on && header_on;
    lay.max_r  = lay.cnt + 7'(lay.origin);
    lay.editor = editor_on;
  end

endmodule

@@ rtl/text_terminal_writer.sv @@
// text_terminal_writer: top level of the text console engine, command FSM,
// cell grid and history memories. Depends on ttw_pkg, ttw_ram, ttw_regs.
//
// Timing: after reset the grid is swept to space/light-grey, one cell a
// cycle, with busy high; configuration writes are taken during the sweep.
// A put that does not scroll or a set-cursor command returns its result
// in the next cycle and the block takes another command right away. Live
// and history reads in range pass through the registered memory read and
// the READ state; a read outside the grid or history answers in the next
// cycle. A put that scrolls by L lines holds busy while each line is pushed
// to history (one grid read and one history write per column), then every
// cell of the content area is moved up or blanked; the result comes at the
// end. Every result is a single-cycle strobe on result_valid with no
// back-pressure, so the receiver must take it then.
module text_terminal_writer (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ttw_pkg::cmd_t cmd,
  output logic          result_valid,
  output ttw_pkg::res_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  ttw_pkg::layout_t lay;

  ttw_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .lay      (lay)
  );

  // Memories. During a scroll, grid reads and writes never hit the same cell
  // in the same cycle: scroll reads always lie at or below rows still to be written.
  logic                        grid_we;
  logic [ttw_pkg::GRID_AW-1:0] grid_waddr, grid_raddr;
  logic [15:0]                 grid_wdata, grid_rdata;
  logic                        hist_we;
  logic [ttw_pkg::HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [15:0]                 hist_wdata, hist_rdata;

  ttw_ram #(.WIDTH(16), .DEPTH(ttw_pkg::GRID_DEPTH)) u_grid (
    .clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
    .raddr(grid_raddr), .rdata(grid_rdata)
  );

  ttw_ram #(.WIDTH(16), .DEPTH(ttw_pkg::HIST_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  // Registers
  ttw_pkg::state_t             state, state_next;
  logic [ttw_pkg::GRID_AW-1:0] clr_addr, clr_addr_next;
  logic [6:0]                  cur_row, cur_row_next;
  logic [7:0]                  cur_col, cur_col_next;
  logic [7:0]                  head, head_next;
  logic [7:0]                  fill, fill_next;
  logic                        rd_hist, rd_hist_next;
  logic [6:0]                  scr_lines, scr_lines_next;
  logic [6:0]                  k_line, k_line_next;
  logic [6:0]                  row_cnt, row_cnt_next;
  logic [7:0]                  col_cnt, col_cnt_next;
  logic [7:0]                  slot, slot_next;
  ttw_pkg::res_t               res, res_next;
  logic                        res_valid, res_valid_next;

  logic [15:0] blank;
  assign blank = {lay.text_color, ttw_pkg::CH_SPACE};

  // Put-character decode: new cursor, cell write and scroll request.
  logic                        put_we;
  logic [ttw_pkg::GRID_AW-1:0] put_waddr;
  logic [15:0]                 put_wdata;
  logic                        put_scroll;
  logic [6:0]                  put_lines, put_row;
  logic [7:0]                  put_col;

  always_comb begin
    logic [7:0] r0, rw, mr, exc;
    logic [8:0] cw;
    mr         = {1'b0, lay.max_r};
    r0         = {1'b0, cur_row};
    if (r0 < 8'(lay.origin)) begin
      r0 = 8'(lay.origin);
    end
    rw         = r0;
    cw         = {1'b0, cur_col};
    // Printable characters land at the cursor before it advances.
    put_waddr  = ttw_pkg::grid_addr(rw[6:0], cw[7:0]);
    exc        = 8'd0;
    put_we     = 1'b0;
    put_wdata  = blank;
    put_scroll = 1'b0;
    put_lines  = 7'd1;
    if (cmd.char_code == ttw_pkg::CH_NEWLINE) begin
      cw = 9'd0;
      rw = r0 + 8'd1;
      if (rw >= mr) begin
        put_scroll = !lay.editor;
        exc        = rw - mr + 8'd1;
        put_lines  = (exc > {1'b0, lay.cnt}) ? lay.cnt : exc[6:0];
        rw         = mr - 8'd1;
      end
    end else if (cmd.char_code == ttw_pkg::CH_BACKSPACE) begin
      if (cw != 9'd0) begin
        cw = cw - 9'd1;
      end else if (r0 > 8'(lay.origin)) begin
        rw = r0 - 8'd1;
        cw = {1'b0, lay.ncols} - 9'd1;
      end
      put_we    = (rw < {1'b0, lay.nrows}) && (cw < {1'b0, lay.ncols});
      put_waddr = ttw_pkg::grid_addr(rw[6:0], cw[7:0]);
    end else begin
      put_we    = (rw < {1'b0, lay.nrows}) && (cw < {1'b0, lay.ncols});
      put_wdata = {lay.text_color, cmd.char_code};
      cw        = cw + 9'd1;
      if (cw >= {1'b0, lay.ncols}) begin
        cw = 9'd0;
        rw = rw + 8'd1;
      end
      if (rw >= mr) begin
        put_scroll = !lay.editor;
        rw         = mr - 8'd1;
      end
    end
    if (rw >= mr) begin
      rw = mr - 8'd1;
    end
    if (cw >= {1'b0, lay.ncols}) begin
      cw = {1'b0, lay.ncols} - 9'd1;
    end
    put_row = rw[6:0];
    put_col = cw[7:0];
  end

  // Set-cursor clamp
  logic [6:0] set_row;
  logic [7:0] set_col;

  always_comb begin
    set_row = (cmd.row < 7'(lay.origin)) ? 7'(lay.origin) : cmd.row;
    if (set_row >= lay.max_r) begin
      set_row = lay.max_r - 7'd1;
    end
    set_col = (cmd.col >= lay.ncols) ? lay.ncols - 8'd1 : cmd.col;
  end

  // Scroll addressing
  logic [6:0] push_row, dst_row;
  logic [7:0] src_off;
  logic [8:0] hist_idx;

  assign push_row = k_line + 7'(lay.origin);
  assign dst_row  = row_cnt + 7'(lay.origin);
  assign src_off  = {1'b0, row_cnt} + {1'b0, scr_lines};
  assign hist_idx = {1'b0, head} + {1'b0, cmd.history_line};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ttw_pkg::ST_CLEAR;
      clr_addr  <= '0;
      cur_row   <= 7'd1;
      cur_col   <= 8'd0;
      head      <= 8'd0;
      fill      <= 8'd0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      head      <= head_next;
      fill      <= fill_next;
      res_valid <= res_valid_next;
    end
    rd_hist   <= rd_hist_next;
    scr_lines <= scr_lines_next;
    k_line    <= k_line_next;
    row_cnt   <= row_cnt_next;
    col_cnt   <= col_cnt_next;
    slot      <= slot_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    head_next      = head;
    fill_next      = fill;
    rd_hist_next   = rd_hist;
    scr_lines_next = scr_lines;
    k_line_next    = k_line;
    row_cnt_next   = row_cnt;
    col_cnt_next   = col_cnt;
    slot_next      = slot;
    res_next       = res;
    res_valid_next = 1'b0;
    grid_we        = 1'b0;
    grid_waddr     = ttw_pkg::grid_addr(dst_row, col_cnt);
    grid_wdata     = blank;
    grid_raddr     = ttw_pkg::grid_addr(push_row, col_cnt);
    hist_we        = 1'b0;
    hist_waddr     = ttw_pkg::hist_addr(slot, col_cnt);
    hist_wdata     = (col_cnt < lay.ncols) ? grid_rdata : blank;
    hist_raddr     = ttw_pkg::hist_addr(ttw_pkg::wrap_line(hist_idx), cmd.col);

    unique case (state)
      ttw_pkg::ST_CLEAR: begin
        grid_we       = 1'b1;
        grid_waddr    = clr_addr;
        grid_wdata    = ttw_pkg::RESET_CELL;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ttw_pkg::GRID_AW'(ttw_pkg::GRID_DEPTH - 1)) begin
          state_next = ttw_pkg::ST_IDLE;
        end
      end

      ttw_pkg::ST_IDLE: begin
        if (start) begin
          unique case (cmd.operation)
            ttw_pkg::OP_PUT: begin
              grid_we      = put_we;
              grid_waddr   = put_waddr;
              grid_wdata   = put_wdata;
              cur_row_next = put_row;
              cur_col_next = put_col;
              if (put_scroll) begin
                scr_lines_next = put_lines;
                k_line_next    = 7'd0;
                state_next     = ttw_pkg::ST_PUSH_LINE;
              end else begin
                res_next       = '{16'd0, 1'b0, put_row, put_col, 1'b0, fill};
                res_valid_next = 1'b1;
              end
            end
            ttw_pkg::OP_READ_LIVE: begin
              grid_raddr = ttw_pkg::grid_addr(cmd.row, cmd.col);
              if (cmd.row >= lay.nrows || cmd.col >= lay.ncols) begin
                res_next       = '{16'd0, 1'b1, cur_row, cur_col, 1'b0, fill};
                res_valid_next = 1'b1;
              end else begin
                rd_hist_next = 1'b0;
                state_next   = ttw_pkg::ST_READ;
              end
            end
            ttw_pkg::OP_READ_HIST: begin
              if (cmd.history_line >= fill || cmd.col >= 8'(ttw_pkg::MAX_COLS)) begin
                res_next       = '{16'd0, 1'b1, cur_row, cur_col, 1'b0, fill};
                res_valid_next = 1'b1;
              end else begin
                rd_hist_next = 1'b1;
                state_next   = ttw_pkg::ST_READ;
              end
            end
            ttw_pkg::OP_SET_CURSOR: begin
              cur_row_next   = set_row;
              cur_col_next   = set_col;
              res_next       = '{16'd0, 1'b0, set_row, set_col, 1'b0, fill};
              res_valid_next = 1'b1;
            end
          endcase
        end
      end

      ttw_pkg::ST_READ: begin
        res_next       = '{(rd_hist ? hist_rdata : grid_rdata), 1'b0, cur_row, cur_col,
                           1'b0, fill};
        res_valid_next = 1'b1;
        state_next     = ttw_pkg::ST_IDLE;
      end

      // Start of one history line; rows beyond the active screen are skipped.
      ttw_pkg::ST_PUSH_LINE: begin
        if (push_row >= lay.nrows) begin
          k_line_next = k_line + 7'd1;
          if (k_line + 7'd1 == scr_lines) begin
            row_cnt_next = 7'd0;
            col_cnt_next = 8'd0;
            state_next   = ttw_pkg::ST_MOVE_RD;
          end
        end else begin
          if (fill >= 8'(ttw_pkg::SCROLLBACK_LINES)) begin
            slot_next = head;
            head_next = ttw_pkg::wrap_line({1'b0, head} + 9'd1);
          end else begin
            slot_next = ttw_pkg::wrap_line({1'b0, head} + {1'b0, fill});
            fill_next = fill + 8'd1;
          end
          col_cnt_next = 8'd0;
          state_next   = ttw_pkg::ST_PUSH_RD;
        end
      end

      ttw_pkg::ST_PUSH_RD: begin
        state_next = ttw_pkg::ST_PUSH_WR;
      end

      ttw_pkg::ST_PUSH_WR: begin
        hist_we = 1'b1;
        if (col_cnt == 8'(ttw_pkg::MAX_COLS - 1)) begin
          k_line_next = k_line + 7'd1;
          if (k_line + 7'd1 == scr_lines) begin
            row_cnt_next = 7'd0;
            col_cnt_next = 8'd0;
            state_next   = ttw_pkg::ST_MOVE_RD;
          end else begin
            state_next = ttw_pkg::ST_PUSH_LINE;
          end
        end else begin
          col_cnt_next = col_cnt + 8'd1;
          state_next   = ttw_pkg::ST_PUSH_RD;
        end
      end

      // Move a cell up by scr_lines rows, or blank it in the bottom rows.
      ttw_pkg::ST_MOVE_RD, ttw_pkg::ST_MOVE_WR: begin
        grid_raddr = ttw_pkg::grid_addr(src_off[6:0] + 7'(lay.origin), col_cnt);
        if (state == ttw_pkg::ST_MOVE_RD && src_off < {1'b0, lay.cnt}) begin
          state_next = ttw_pkg::ST_MOVE_WR;
        end else begin
          grid_we    = 1'b1;
          grid_wdata = (state == ttw_pkg::ST_MOVE_WR) ? grid_rdata : blank;
          state_next = ttw_pkg::ST_MOVE_RD;
          if (col_cnt == lay.ncols - 8'd1) begin
            col_cnt_next = 8'd0;
            row_cnt_next = row_cnt + 7'd1;
            if (row_cnt == lay.cnt - 7'd1) begin
              res_next       = '{16'd0, 1'b0, cur_row, cur_col, 1'b1, fill};
              res_valid_next = 1'b1;
              state_next     = ttw_pkg::ST_IDLE;
            end
          end else begin
            col_cnt_next = col_cnt + 8'd1;
          end
        end
      end
    endcase
  end

  assign busy         = (state != ttw_pkg::ST_IDLE);
  assign result_valid = res_valid;
  assign result       = res;

endmodule

@@ rtl/ttw_checker.sv @@
// ttw_checker: port-level assertions for the text terminal writer, bound to
// the top level. Depends on ttw_pkg and text_terminal_writer.
module ttw_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input ttw_pkg::cmd_t cmd,
  input logic          result_valid,
  input ttw_pkg::res_t result
);

  // Set-cursor transactions finish in the next cycle.
  a_set_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.operation == ttw_pkg::OP_SET_CURSOR |=> result_valid)
    else $error("set cursor result missing");

  // Failed reads return a zero cell word.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.read_error |-> result.read_entry == 16'd0)
    else $error("read error with nonzero entry");

  // A scroll only ends a busy stretch.
  a_scroll_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.scrolled |-> $past(busy))
    else $error("scroll result without busy");

  // Cursor and history fill stay inside their ranges.
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.cursor_row < 7'(ttw_pkg::MAX_ROWS)
                  && result.cursor_col < 8'(ttw_pkg::MAX_COLS)
                  && result.lines_kept <= 8'(ttw_pkg::SCROLLBACK_LINES))
    else $error("result out of range");

endmodule

bind text_terminal_writer ttw_checker u_ttw_checker (.*);
